>>> design/lcvp_pkg.sv
// ----------------------------------------------------------------------------
// lcvp_pkg
// Shared types and constants of the looping clip voice player.
// ----------------------------------------------------------------------------
package lcvp_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int CLIP_DEPTH_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 17;
  localparam int VOL_W    = 7;
  localparam int VOL_FULL = 100;

  // q = (n * RECIP_M) >> RECIP_SHIFT equals n / 100 for n < 2^22
  localparam int MUL_A_W     = 23;
  localparam int MUL_B_W     = 23;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int RECIP_SHIFT = 29;
  localparam logic [MUL_B_W-1:0] RECIP_M = 23'd5368710;

  typedef enum logic [2:0] {
    KIND_RENDER     = 3'd0,
    KIND_CONTINUE   = 3'd1,
    KIND_PAUSE      = 3'd2,
    KIND_PLAY_ONCE  = 3'd3,
    KIND_SET_VOLUME = 3'd4,
    KIND_LOAD_WORD  = 3'd5,
    KIND_SET_LENGTH = 3'd6,
    KIND_UNUSED     = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         channel;
    logic signed [7:0]  volume_request;
    logic [12:0]        clip_position;
    logic signed [15:0] clip_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         out_channel;
    logic               last;
    logic               status;
  } out_item_t;

endpackage

>>> design/lcvp_ram.sv
// ----------------------------------------------------------------------------
// lcvp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcvp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/lcvp_mul.sv
// ----------------------------------------------------------------------------
// lcvp_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module lcvp_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lcvp_pkg::MUL_A_W-1:0]  a,
  input  logic [lcvp_pkg::MUL_B_W-1:0]  b,
  output logic [lcvp_pkg::MUL_P_W-1:0]  p
);
  import lcvp_pkg::*;

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

  assign p = p_r;

endmodule

>>> design/looping_clip_voice_player_top.sv
// ----------------------------------------------------------------------------
// looping_clip_voice_player_top
// Per-channel clip player: commands, clip loading and frame rendering.
// ----------------------------------------------------------------------------
// A command is taken while idle and its result strobes on the next cycle.
// A render frame walks the active channels in order: a silent channel goes
// straight to its result, a sounding channel goes through a clip memory read,
// then two passes through the one shared multiplier for volume and the divide
// by 100, then its result, with busy high until the last result strobes.
// Results are strobed for one cycle and cannot be held off.
module looping_clip_voice_player_top #(
  parameter int CHANNELS   = lcvp_pkg::CHANNELS_DEF,
  parameter int CLIP_DEPTH = lcvp_pkg::CLIP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lcvp_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output lcvp_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata
);
  import lcvp_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int POS_W  = $clog2(CLIP_DEPTH);
  localparam int LEN_W  = $clog2(CLIP_DEPTH + 1);
  localparam int ADDR_W = CH_W + POS_W;
  localparam int MEM_DEPTH = CHANNELS * (2 ** POS_W);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic             sign_r, sign_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [3:0]       active_r;

  logic [LEN_W-1:0] len_r    [CHANNELS];
  logic [LEN_W-1:0] cur_r    [CHANNELS];
  logic             paused_r [CHANNELS];
  logic             shot_r   [CHANNELS];
  logic [VOL_W-1:0] vol_r    [CHANNELS];

  logic             accept;
  logic [CNT_W-1:0] cnt;
  logic             ch_ok;
  logic [CH_W-1:0]  sel;
  logic [LEN_W-1:0] len_sel, cur_sel, cur_eff, cur_inc;
  logic             silent, wrap, zero_out, last_ch;
  logic [VOL_W-1:0] vol_sat;
  logic [LEN_W-1:0] len_set;

  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic signed [MAG_W-1:0] s_ext;
  logic [MAG_W-1:0]        mag, quo;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign cnt     = (32'(active_r) > CHANNELS) ? CNT_W'(CHANNELS) : CNT_W'(active_r);
  assign ch_ok   = 32'(in_item.channel) < 32'(cnt);
  assign sel     = (state_r == ST_IDLE) ? in_item.channel[CH_W-1:0] : idx_r;
  assign len_sel = len_r[sel];
  assign cur_sel = cur_r[sel];
  assign silent  = (paused_r[sel] && !shot_r[sel]) || (len_sel == '0);
  assign wrap    = (cur_sel >= len_sel);
  assign cur_eff = wrap ? '0 : cur_sel;
  assign cur_inc = cur_eff + 1'b1;
  assign zero_out = silent || (wrap && shot_r[sel]);
  assign last_ch = (32'(idx_r) + 1 == 32'(cnt));

  assign vol_sat = (in_item.volume_request < 8'sd0)   ? '0 :
                   (in_item.volume_request > 8'sd100) ? VOL_W'(VOL_FULL) :
                   in_item.volume_request[VOL_W-1:0];
  assign len_set = (32'(in_item.clip_position) > CLIP_DEPTH) ? LEN_W'(CLIP_DEPTH) :
                   LEN_W'(in_item.clip_position);

  assign mem_we    = accept && ch_ok && (in_item.kind == KIND_LOAD_WORD) &&
                     (32'(in_item.clip_position) < CLIP_DEPTH);
  assign mem_waddr = {in_item.channel[CH_W-1:0], POS_W'(in_item.clip_position)};
  assign mem_re    = (state_r == ST_CHECK) && !zero_out;
  assign mem_raddr = {idx_r, cur_eff[POS_W-1:0]};

  lcvp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_clip_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_item.clip_sample),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s_ext = {mem_rdata[SAMPLE_W-1], mem_rdata};
  assign mag   = s_ext[MAG_W-1] ? MAG_W'(-s_ext) : MAG_W'(s_ext);
  assign quo   = mul_p[RECIP_SHIFT +: MAG_W];

  always_comb begin
    mul_en = 1'b0;
    mul_a  = MUL_A_W'(mag);
    mul_b  = MUL_B_W'(vol_r[idx_r]);
    unique case (state_r)
      ST_FETCH: mul_en = 1'b1;
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MUL_A_W-1:0];
        mul_b  = RECIP_M;
      end
      default: ;
    endcase
  end

  lcvp_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    sign_nxt       = sign_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.kind == KIND_RENDER) begin
            if (cnt != '0) begin
              idx_nxt   = '0;
              state_nxt = ST_CHECK;
            end
          end else begin
            out_strobe_nxt           = 1'b1;
            out_item_nxt.sample      = '0;
            out_item_nxt.out_channel = in_item.channel;
            out_item_nxt.last        = 1'b1;
            out_item_nxt.status      = (in_item.kind != KIND_UNUSED) && !ch_ok;
          end
        end
      end
      ST_CHECK: begin
        if (zero_out) begin
          out_strobe_nxt           = 1'b1;
          out_item_nxt.sample      = '0;
          out_item_nxt.out_channel = 4'(idx_r);
          out_item_nxt.last        = last_ch;
          out_item_nxt.status      = 1'b0;
          state_nxt = last_ch ? ST_IDLE : ST_CHECK;
          idx_nxt   = last_ch ? idx_r : CH_W'(idx_r + 1'b1);
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        sign_nxt  = mem_rdata[SAMPLE_W-1];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        out_strobe_nxt           = 1'b1;
        out_item_nxt.sample      = sign_r ? SAMPLE_W'(-quo) : SAMPLE_W'(quo);
        out_item_nxt.out_channel = 4'(idx_r);
        out_item_nxt.last        = last_ch;
        out_item_nxt.status      = 1'b0;
        state_nxt = last_ch ? ST_IDLE : ST_CHECK;
        idx_nxt   = last_ch ? idx_r : CH_W'(idx_r + 1'b1);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
      active_r     <= 4'd2;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    sign_r     <= sign_nxt;
    out_item_r <= out_item_nxt;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        len_r[i]    <= '0;
        cur_r[i]    <= '0;
        paused_r[i] <= 1'b1;
        shot_r[i]   <= 1'b0;
        vol_r[i]    <= VOL_W'(VOL_FULL);
      end
    end else if (state_r == ST_IDLE) begin
      if (accept && ch_ok) begin
        unique case (in_item.kind)
          KIND_CONTINUE: begin
            paused_r[sel] <= 1'b0;
            shot_r[sel]   <= 1'b0;
          end
          KIND_PAUSE: begin
            paused_r[sel] <= 1'b1;
            shot_r[sel]   <= 1'b0;
          end
          KIND_PLAY_ONCE: begin
            cur_r[sel] <= '0;
            if (paused_r[sel]) begin
              shot_r[sel] <= 1'b1;
            end
          end
          KIND_SET_VOLUME: vol_r[sel] <= vol_sat;
          KIND_SET_LENGTH: len_r[sel] <= len_set;
          default: ;
        endcase
      end
    end else if (state_r == ST_CHECK && !silent) begin
      if (wrap && shot_r[sel]) begin
        cur_r[sel]  <= '0;
        shot_r[sel] <= 1'b0;
      end else if (cur_inc >= len_sel && shot_r[sel]) begin
        cur_r[sel]  <= '0;
        shot_r[sel] <= 1'b0;
      end else begin
        cur_r[sel] <= cur_inc;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef ASSERT_OFF
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.kind != KIND_RENDER |=> out_strobe && out_item.last)
    else $error("command transfer without result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.last |-> !busy)
    else $error("busy after final result");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status |-> out_item.sample == '0 && out_item.last)
    else $error("not-found result carries data");

  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("frame ended early");
`endif

endmodule

>>> tb/looping_clip_voice_player_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// looping_clip_voice_player_top_tb
// Drives commands, clip loads and render frames into the voice player across
// several channel-count settings, with random idle gaps. A scoreboard keeps
// its own copy of every channel's state, predicts each result and compares
// the strobed results field by field, in order.
// ----------------------------------------------------------------------------
module looping_clip_voice_player_top_tb;
  import lcvp_pkg::*;

  localparam int               CH_MAX      = CHANNELS_DEF;
  localparam int               DEPTH       = CLIP_DEPTH_DEF;
  localparam int               QUIET_LIMIT = 2000;
  localparam int               SETTLE      = 40;
  localparam int               PHASE_ITEMS = 45;

  class voice_scoreboard;
    logic signed [15:0] clip_mem [CH_MAX*DEPTH];
    bit                 written  [CH_MAX*DEPTH];
    int unsigned        clip_len [CH_MAX];
    int unsigned        cursor   [CH_MAX];
    bit                 paused   [CH_MAX];
    bit                 one_shot [CH_MAX];
    int                 volume   [CH_MAX];
    logic [3:0]         active;
    out_item_t          expected [$];
    int                 mismatches;

    function new();
      for (int c = 0; c < CH_MAX; c++) begin
        clip_len[c] = 0;
        cursor[c]   = 0;
        paused[c]   = 1'b1;
        one_shot[c] = 1'b0;
        volume[c]   = VOL_FULL;
      end
      active     = 4'd2;
      mismatches = 0;
    endfunction

    function int unsigned live_channels();
      return (active < CH_MAX) ? active : CH_MAX;
    endfunction

    function void set_active(logic [3:0] v);
      active = v;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void add_expected(out_item_t r);
      expected = {expected, r};
    endfunction

    // first channel whose next render would read a clip word never loaded
    function bit missing_word(output int ch, output int addr);
      int unsigned cur;
      ch   = 0;
      addr = 0;
      for (int c = 0; c < live_channels(); c++) begin
        if ((paused[c] && !one_shot[c]) || clip_len[c] == 0) continue;
        if (cursor[c] >= clip_len[c] && one_shot[c]) continue;
        cur = (cursor[c] >= clip_len[c]) ? 0 : cursor[c];
        if (!written[c*DEPTH + cur]) begin
          ch   = c;
          addr = cur;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function logic signed [15:0] render_voice(int c);
      int s;
      if ((paused[c] && !one_shot[c]) || clip_len[c] == 0) return '0;
      if (cursor[c] >= clip_len[c]) begin
        cursor[c] = 0;
        if (one_shot[c]) begin
          one_shot[c] = 1'b0;
          return '0;
        end
      end
      s = clip_mem[c*DEPTH + cursor[c]];
      s = s * volume[c] / VOL_FULL;
      cursor[c]++;
      if (cursor[c] >= clip_len[c] && one_shot[c]) begin
        one_shot[c] = 1'b0;
        cursor[c]   = 0;
      end
      return 16'(s);
    endfunction

    function void note_request(in_item_t it);
      int unsigned n;
      out_item_t   r;
      logic [2:0]  k;
      int          v;
      int          ch;
      n = live_channels();
      k = it.kind;
      if (it.kind == KIND_RENDER) begin
        for (int c = 0; c < n; c++) begin
          r.sample      = render_voice(c);
          r.out_channel = 4'(c);
          r.last        = (c == n - 1);
          r.status      = 1'b0;
          add_expected(r);
        end
        return;
      end
      r             = '0;
      r.out_channel = it.channel;
      r.last        = 1'b1;
      ch            = it.channel;
      if (k == KIND_UNUSED) begin
        add_expected(r);
        return;
      end
      if (ch >= n) begin
        r.status = 1'b1;
        add_expected(r);
        return;
      end
      case (it.kind)
        KIND_CONTINUE: begin
          paused[ch]   = 1'b0;
          one_shot[ch] = 1'b0;
        end
        KIND_PAUSE: begin
          paused[ch]   = 1'b1;
          one_shot[ch] = 1'b0;
        end
        KIND_PLAY_ONCE: begin
          cursor[ch] = 0;
          if (paused[ch]) one_shot[ch] = 1'b1;
        end
        KIND_SET_VOLUME: begin
          v = $signed(it.volume_request);
          if (v < 0) v = 0;
          if (v > VOL_FULL) v = VOL_FULL;
          volume[ch] = v;
        end
        KIND_LOAD_WORD: begin
          if (it.clip_position < DEPTH) begin
            clip_mem[ch*DEPTH + it.clip_position] = it.clip_sample;
            written[ch*DEPTH + it.clip_position]  = 1'b1;
          end
        end
        default: begin
          clip_len[ch] = (it.clip_position > DEPTH) ? DEPTH : it.clip_position;
        end
      endcase
      add_expected(r);
    endfunction

    function void report(string what, int want, int got);
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual sample %0d channel %0d",
                 $time, got.sample, got.out_channel);
        return;
      end
      want = expected.pop_front();
      if (got.sample !== want.sample)           report("sample", want.sample, got.sample);
      if (got.out_channel !== want.out_channel) report("channel", want.out_channel, got.out_channel);
      if (got.last !== want.last)               report("last", want.last, got.last);
      if (got.status !== want.status)           report("status", want.status, got.status);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we;
  logic [3:0] cfg_wdata;

  voice_scoreboard sb;
  bit              gaps_on;
  int              quiet_cycles;

  looping_clip_voice_player_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_item);
      if (start && !busy) sb.note_request(in_item);
      if (cfg_we) sb.set_active(cfg_wdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("looping_clip_voice_player_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int idle_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // entered and left at a falling edge; start stays high for a back-to-back transfer
  task automatic issue(in_item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic cmd(kind_t k, logic [3:0] ch, logic [7:0] vol, logic [12:0] pos,
                     logic [15:0] smp);
    in_item_t it;
    it.kind           = k;
    it.channel        = ch;
    it.volume_request = vol;
    it.clip_position  = pos;
    it.clip_sample    = smp;
    issue(it);
  endtask

  // loads any clip word the coming frame would read before it was written
  task automatic render_frame();
    int c;
    int a;
    while (sb.missing_word(c, a))
      cmd(KIND_LOAD_WORD, 4'(c), 8'($urandom), 13'(a), 16'($urandom));
    cmd(KIND_RENDER, 4'($urandom), 8'($urandom), 13'($urandom), 16'($urandom));
  endtask

  task automatic set_channels(logic [3:0] v);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic random_transfer();
    int          r;
    int unsigned n;
    logic [3:0]  ch;
    logic [12:0] pos;
    n = sb.live_channels();
    ch = (n > 0 && $urandom_range(0, 99) < 85) ? 4'($urandom_range(0, n - 1))
                                                : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 30) begin
      render_frame();
    end else if (r < 55) begin
      r = $urandom_range(0, 99);
      pos = (r < 80) ? 13'($urandom_range(0, 63)) : (r < 88) ? 13'(DEPTH - 1)
                                                             : 13'($urandom);
      cmd(KIND_LOAD_WORD, ch, 8'($urandom), pos, 16'($urandom));
    end else if (r < 67) begin
      r = $urandom_range(0, 99);
      pos = (r < 70) ? 13'($urandom_range(1, 16)) : (r < 80) ? 13'd0
          : (r < 90) ? 13'($urandom) : 13'(DEPTH);
      cmd(KIND_SET_LENGTH, ch, 8'($urandom), pos, 16'($urandom));
    end else if (r < 75) begin
      cmd(KIND_CONTINUE, ch, 8'($urandom), 13'($urandom), 16'($urandom));
    end else if (r < 82) begin
      cmd(KIND_PAUSE, ch, 8'($urandom), 13'($urandom), 16'($urandom));
    end else if (r < 90) begin
      cmd(KIND_PLAY_ONCE, ch, 8'($urandom), 13'($urandom), 16'($urandom));
    end else if (r < 98) begin
      cmd(KIND_SET_VOLUME, ch, 8'($urandom), 13'($urandom), 16'($urandom));
    end else begin
      cmd(KIND_UNUSED, ch, 8'($urandom), 13'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 15 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      random_transfer();
    end
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 4'd0;
    gaps_on   = 1'b1;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setting: two channels, everything paused
    render_frame();
    cmd(KIND_CONTINUE, 4'd15, 8'd0, 13'd0, 16'd0);
    cmd(KIND_PAUSE, 4'd2, 8'd0, 13'd0, 16'd0);
    cmd(KIND_UNUSED, 4'd9, 8'hff, 13'h1fff, 16'hffff);
    cmd(KIND_LOAD_WORD, 4'd0, 8'd0, 13'd0, 16'h7fff);
    cmd(KIND_LOAD_WORD, 4'd0, 8'd0, 13'd1, 16'h8000);
    cmd(KIND_LOAD_WORD, 4'd0, 8'd0, 13'd2, 16'hffff);
    cmd(KIND_LOAD_WORD, 4'd0, 8'd0, 13'd3, 16'h00c9);
    cmd(KIND_LOAD_WORD, 4'd0, 8'd0, 13'(DEPTH), 16'h1234);
    cmd(KIND_LOAD_WORD, 4'd1, 8'd0, 13'h1fff, 16'h5555);
    cmd(KIND_SET_LENGTH, 4'd0, 8'd0, 13'h1fff, 16'd0);
    cmd(KIND_SET_LENGTH, 4'd0, 8'd0, 13'd4, 16'd0);
    cmd(KIND_SET_VOLUME, 4'd0, 8'h7f, 13'd0, 16'd0);
    cmd(KIND_CONTINUE, 4'd0, 8'd0, 13'd0, 16'd0);
    render_frame();
    cmd(KIND_SET_VOLUME, 4'd0, 8'h80, 13'd0, 16'd0);
    render_frame();
    cmd(KIND_SET_VOLUME, 4'd0, 8'd33, 13'd0, 16'd0);
    repeat (3) render_frame();
    // one-shot runs to the end of the clip, then silence
    cmd(KIND_PAUSE, 4'd0, 8'd0, 13'd0, 16'd0);
    cmd(KIND_PLAY_ONCE, 4'd0, 8'd0, 13'd0, 16'd0);
    repeat (5) render_frame();
    // one-shot with the cursor left past a shortened clip
    cmd(KIND_PLAY_ONCE, 4'd0, 8'd0, 13'd0, 16'd0);
    repeat (2) render_frame();
    cmd(KIND_SET_LENGTH, 4'd0, 8'd0, 13'd1, 16'd0);
    render_frame();
    cmd(KIND_CONTINUE, 4'd1, 8'd0, 13'd0, 16'd0);
    cmd(KIND_PLAY_ONCE, 4'd1, 8'd0, 13'd0, 16'd0);
    render_frame();

    set_channels(4'd8);
    random_phase(PHASE_ITEMS);
    set_channels(4'd0);
    random_phase(15);
    set_channels(4'd15);
    random_phase(PHASE_ITEMS);
    set_channels(4'd1);
    random_phase(PHASE_ITEMS);
    set_channels(4'd5);
    random_phase(PHASE_ITEMS);
    set_channels(4'($urandom_range(2, 7)));
    random_phase(PHASE_ITEMS);

    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("looping_clip_voice_player_top_tb OK");
    end else begin
      $display("looping_clip_voice_player_top_tb NOT OK");
    end
    $finish;
  end

endmodule
